>>> hw/rtl/trdec_pkg.sv
// Shared types and constants for the time-tag record decoder.
package trdec_pkg;

  localparam int unsigned RecordW    = 32;
  localparam int unsigned TimeW      = 64;
  localparam int unsigned ChannelW   = 7;
  localparam int unsigned DelayW     = 15;
  localparam int unsigned KindW      = 2;
  localparam int unsigned CountW     = 10;
  localparam int unsigned TagW       = 25;
  localparam int unsigned RawChW     = 6;
  localparam int unsigned ResultW    = KindW + ChannelW + DelayW + TimeW;
  localparam int unsigned OutBytesW  = ((ResultW + 7) / 8) * 8;
  localparam int unsigned CfgIndexW  = 1;
  localparam int unsigned CfgDataW   = 2;

  localparam logic [TimeW-1:0]  T3Wrap     = 64'd1024;
  localparam logic [TimeW-1:0]  T2WrapOld  = 64'd33552000;
  localparam logic [TimeW-1:0]  T2WrapNew  = 64'd33554432;
  localparam logic [RawChW-1:0] OvfChannel = 6'h3F;
  localparam logic [RawChW-1:0] MarkerMax  = 6'd15;

  localparam logic [1:0] HwVersionOld   = 2'd1;
  localparam logic [1:0] HwVersionReset = 2'd2;

  localparam logic [CfgIndexW-1:0] CfgIdxFormat  = 1'd0;
  localparam logic [CfgIndexW-1:0] CfgIdxVersion = 1'd1;

  typedef enum logic [KindW-1:0] {
    KIND_NONE   = 2'd0,
    KIND_PHOTON = 2'd1,
    KIND_MARKER = 2'd2,
    KIND_SYNC   = 2'd3
  } kind_e;

  typedef enum logic {
    FMT_T3 = 1'b0,
    FMT_T2 = 1'b1
  } format_e;

  typedef struct packed {
    format_e    format;
    logic [1:0] hw_version;
  } cfg_t;

  // Packed so that kind lands in the lowest bits of the output word.
  typedef struct packed {
    logic [TimeW-1:0]    event_time;
    logic [DelayW-1:0]   delay;
    logic [ChannelW-1:0] channel;
    kind_e               kind;
  } result_t;

endpackage

>>> hw/rtl/trdec_cfg.sv
// Configuration registers of the time-tag record decoder.
module trdec_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [trdec_pkg::CfgIndexW-1:0]   wr_index_i,
  input  logic [trdec_pkg::CfgDataW-1:0]    wr_data_i,
  output trdec_pkg::cfg_t                   cfg_o
);
  import trdec_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        CfgIdxFormat:  cfg_d.format     = format_e'(wr_data_i[0]);
        CfgIdxVersion: cfg_d.hw_version = wr_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.format     <= FMT_T3;
      cfg_q.hw_version <= HwVersionReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/trdec_decode.sv
// Combinational record decode and overflow base update.
module trdec_decode (
  input  logic [trdec_pkg::RecordW-1:0] record_i,
  input  trdec_pkg::cfg_t               cfg_i,
  input  logic [trdec_pkg::TimeW-1:0]   base_i,
  output trdec_pkg::result_t            result_o,
  output logic [trdec_pkg::TimeW-1:0]   base_next_o
);
  import trdec_pkg::*;

  logic [CountW-1:0] count;
  logic [DelayW-1:0] dly;
  logic [TagW-1:0]   tag;
  logic [RawChW-1:0] ch;
  logic              special;
  logic              is_ovf;
  logic              is_marker;
  logic              old_fw;
  logic [TimeW-1:0]  offset;
  logic [TimeW-1:0]  incr;
  logic [TimeW-1:0]  stamp;

  assign count   = record_i[CountW-1:0];
  assign dly     = record_i[CountW +: DelayW];
  assign tag     = record_i[TagW-1:0];
  assign ch      = record_i[TagW +: RawChW];
  assign special = record_i[RecordW-1];
  assign old_fw  = (cfg_i.hw_version == HwVersionOld);

  assign is_ovf    = special && (ch == OvfChannel);
  assign is_marker = special && (ch != '0) && (ch <= MarkerMax);

  // Wrap periods are powers of two apart from the old T2 period, so the
  // count scaling is a shift.
  always_comb begin
    if (cfg_i.format == FMT_T2) begin
      offset = {{(TimeW-TagW){1'b0}}, tag};
      if (old_fw) begin
        incr = T2WrapOld;
      end else if (tag == '0) begin
        incr = T2WrapNew;
      end else begin
        incr = {{(TimeW-2*TagW){1'b0}}, tag, {TagW{1'b0}}};
      end
    end else begin
      offset = {{(TimeW-CountW){1'b0}}, count};
      if (old_fw || (count == '0)) begin
        incr = T3Wrap;
      end else begin
        incr = {{(TimeW-2*CountW){1'b0}}, count, {CountW{1'b0}}};
      end
    end
  end

  assign stamp       = base_i + offset;
  assign base_next_o = is_ovf ? (base_i + incr) : base_i;

  always_comb begin
    result_o = '0;
    if (!special) begin
      result_o.kind       = KIND_PHOTON;
      result_o.event_time = stamp;
      if (cfg_i.format == FMT_T2) begin
        result_o.channel = {1'b0, ch} + 7'd1;
      end else begin
        result_o.channel = {1'b0, ch};
        result_o.delay   = dly;
      end
    end else if (is_marker) begin
      result_o.kind       = KIND_MARKER;
      result_o.channel    = {1'b0, ch};
      result_o.event_time = stamp;
    end else if ((cfg_i.format == FMT_T2) && (ch == '0)) begin
      result_o.kind       = KIND_SYNC;
      result_o.event_time = stamp;
    end
  end

endmodule

>>> hw/rtl/timetag_record_decoder_core.sv
// Top level of the time-tag record decoder: input register, decode, result register.
//
// Usage: raw 32-bit records arrive on the s_axis channel, one per transfer,
// in s_axis_tdata. Each record yields exactly one result transfer on the
// m_axis channel carrying kind, channel, delay and event_time. Overflow and
// unused special records come out with kind none and all other fields zero.
// The cfg channel writes register 0 (record format, 0 = T3, 1 = T2) and
// register 1 (firmware version); cfg_ready_o is always high. Writes are
// meant to happen only while no record is in flight.
// A record accepted into the input register moves on to the result register
// and is offered on m_axis from there. Throughput: one record per cycle while
// the receiver keeps up; the overflow base is a single 64-bit register updated by
// one add in the decode stage, so records follow each other without gaps.
// When the receiver stalls, the result register holds its word and the
// input register takes one more record; s_axis_tready falls only when both
// are full. Reset clears both valid flags, the overflow base, and sets the
// registers to T3 layout and firmware version 2.
module timetag_record_decoder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream. tdata fields from bit 0: record[31:0].
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [trdec_pkg::RecordW-1:0]     s_axis_tdata,
  // Result stream. tdata fields from bit 0: kind[1:0], channel[8:2],
  // delay[23:9], event_time[87:24].
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [trdec_pkg::OutBytesW-1:0]   m_axis_tdata,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [trdec_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [trdec_pkg::CfgDataW-1:0]    cfg_data_i
);
  import trdec_pkg::*;

  cfg_t              cfg;
  logic              in_valid_q;
  logic [RecordW-1:0] in_record_q;
  logic              out_valid_q;
  result_t           out_result_q;
  logic [TimeW-1:0]  base_q, base_d;
  result_t           dec_result;
  logic              out_load;
  logic              in_load;

  assign cfg_ready_o = 1'b1;

  trdec_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  trdec_decode u_decode (
    .record_i    (in_record_q),
    .cfg_i       (cfg),
    .base_i      (base_q),
    .result_o    (dec_result),
    .base_next_o (base_d)
  );

  // The result register can take a new word when it is empty or being drained.
  assign out_load      = !out_valid_q || m_axis_tready;
  assign in_load       = !in_valid_q || out_load;
  assign s_axis_tready = in_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
    end else begin
      if (in_load) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
      // The base is updated exactly once per record, as it moves to the output.
      if (out_load && in_valid_q) begin
        base_q <= base_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && s_axis_tvalid) begin
      in_record_q <= s_axis_tdata;
    end
    if (out_load && in_valid_q) begin
      out_result_q <= dec_result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutBytesW'(out_result_q);

endmodule

>>> hw/rtl/trdec_checker.sv
// Port-level assertions for the time-tag record decoder, bound to the top level.
module trdec_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [trdec_pkg::OutBytesW-1:0] m_axis_tdata
);
  import trdec_pkg::*;

  logic [KindW-1:0]    kind;
  logic [ChannelW-1:0] channel;
  logic [DelayW-1:0]   delay;

  assign kind    = m_axis_tdata[KindW-1:0];
  assign channel = m_axis_tdata[KindW +: ChannelW];
  assign delay   = m_axis_tdata[KindW+ChannelW +: DelayW];

  // A stalled result holds its word.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Input is refused only when the result register is full and stalled.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input refused without an output stall");

  // A result of kind none carries nothing else.
  a_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (kind == KIND_NONE) |-> (m_axis_tdata[OutBytesW-1:KindW] == '0))
    else $error("kind none with nonzero fields");

  // Markers are channels one to fifteen and carry no delay.
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (kind == KIND_MARKER) |->
      (channel != '0) && (channel <= 7'd15) && (delay == '0))
    else $error("malformed marker result");

  // Sync results carry neither channel nor delay.
  a_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (kind == KIND_SYNC) |-> (channel == '0) && (delay == '0))
    else $error("malformed sync result");

endmodule

bind timetag_record_decoder_core trdec_checker u_trdec_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> bench/tb_timetag_record_decoder_core.sv
// Self-checking stream testbench for the time-tag record decoder core.
module tb_timetag_record_decoder_core;
  import trdec_pkg::*;

  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned ResetCycles   = 5;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned HoldCycles    = 60;
  localparam int unsigned EndPause      = 8;
  localparam int unsigned BlockItems    = 140;
  localparam int unsigned WrapRecords   = 128;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_valid = 1'b0;
  logic                 s_axis_tready;
  logic [RecordW-1:0]   s_data  = '0;
  logic                 m_axis_tvalid;
  logic                 m_ready = 1'b0;
  logic [OutBytesW-1:0] m_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;

  // Records still to be offered and decoded results still owed by the block.
  logic [RecordW-1:0] record_q[$];
  result_t            result_q[$];

  // Shadow copy of the block's registers and its running overflow base.
  format_e     fmt_cfg   = FMT_T3;
  logic [1:0]  ver_cfg   = HwVersionReset;
  logic [63:0] base_time = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned fail_count    = 0;
  int unsigned idle_cycles   = 0;
  logic        hold_req      = 1'b0;
  logic        hold_done     = 1'b0;
  int unsigned hold_left     = 0;

  timetag_record_decoder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Decodes one record against the shadow registers and advances the base.
  function automatic result_t decode_record(logic [RecordW-1:0] rec);
    result_t     res;
    logic        special;
    logic [5:0]  ch;
    logic [9:0]  sync_cnt;
    logic [14:0] dly;
    logic [24:0] tag;
    res      = '0;
    res.kind = KIND_NONE;
    special  = rec[31];
    ch       = rec[30:25];
    dly      = rec[24:10];
    sync_cnt = rec[9:0];
    tag      = rec[24:0];
    if (fmt_cfg == FMT_T3) begin
      if (!special) begin
        res.kind       = KIND_PHOTON;
        res.channel    = {1'b0, ch};
        res.delay      = dly;
        res.event_time = base_time + TimeW'(sync_cnt);
      end else if (ch == OvfChannel) begin
        // A zero count, or the old firmware, means a single wrap period.
        if (sync_cnt == '0 || ver_cfg == HwVersionOld) begin
          base_time = base_time + T3Wrap;
        end else begin
          base_time = base_time + T3Wrap * TimeW'(sync_cnt);
        end
      end else if (ch >= 6'd1 && ch <= MarkerMax) begin
        res.kind       = KIND_MARKER;
        res.channel    = {1'b0, ch};
        res.event_time = base_time + TimeW'(sync_cnt);
      end
    end else begin
      if (!special) begin
        // T2 photon channels are numbered from one.
        res.kind       = KIND_PHOTON;
        res.channel    = {1'b0, ch} + 7'd1;
        res.event_time = base_time + TimeW'(tag);
      end else if (ch == OvfChannel) begin
        if (ver_cfg == HwVersionOld) begin
          base_time = base_time + T2WrapOld;
        end else if (tag == '0) begin
          base_time = base_time + T2WrapNew;
        end else begin
          base_time = base_time + T2WrapNew * TimeW'(tag);
        end
      end else if (ch >= 6'd1 && ch <= MarkerMax) begin
        res.kind       = KIND_MARKER;
        res.channel    = {1'b0, ch};
        res.event_time = base_time + TimeW'(tag);
      end else if (ch == 6'd0) begin
        res.kind       = KIND_SYNC;
        res.event_time = base_time + TimeW'(tag);
      end
    end
    return res;
  endfunction

  function automatic logic [RecordW-1:0] t3_rec(logic sp, logic [5:0] ch, logic [14:0] dly,
                                                logic [9:0] cnt);
    return {sp, ch, dly, cnt};
  endfunction

  function automatic logic [RecordW-1:0] t2_rec(logic sp, logic [5:0] ch, logic [24:0] tag);
    return {sp, ch, tag};
  endfunction

  // Mostly well-formed photon, marker, overflow, sync and unused records; raw noise.
  function automatic logic [RecordW-1:0] random_record();
    int unsigned pick;
    logic        sp;
    logic [5:0]  ch;
    logic [24:0] low;
    pick = $urandom_range(99);
    low  = 25'($urandom);
    if (pick < 45) begin
      sp = 1'b0;
      ch = 6'($urandom_range(63));
    end else if (pick < 65) begin
      sp = 1'b1;
      ch = 6'($urandom_range(15, 1));
    end else if (pick < 80) begin
      sp = 1'b1;
      ch = OvfChannel;
      if ($urandom_range(7) == 0) low = '0;
    end else if (pick < 90) begin
      sp = 1'b1;
      ch = ($urandom_range(3) == 0) ? 6'd0 : 6'($urandom_range(62, 16));
    end else begin
      return $urandom;
    end
    return {sp, ch, low};
  endfunction

  // Returns at a falling edge once nothing is queued, offered or owed.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (record_q.size() != 0 || s_valid || result_q.size() != 0);
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Sender: keeps a record on the bus until its transfer, then may idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else if (!s_valid || s_axis_tready) begin
      if (record_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_valid <= 1'b1;
        s_data  <= record_q.pop_front();
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, and one long hold-off when requested.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      m_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_ready   <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: checks results, predicts accepted records, tracks register writes.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    logic    moved;
    logic    busy;
    moved = 1'b0;
    busy  = record_q.size() != 0 || s_valid || result_q.size() != 0 || cfg_valid;
    if (rst_ni) begin
      // Results are checked before this edge's record is predicted.
      if (m_axis_tvalid && m_ready) begin
        moved = 1'b1;
        got   = result_t'(m_data[ResultW-1:0]);
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $display("result with nothing expected: kind %0d ch %0d delay %0d time %0h",
                     got.kind, got.channel, got.delay, got.event_time);
          end
        end else begin
          want = result_q.pop_front();
          if (got.kind !== want.kind || got.channel !== want.channel ||
              got.delay !== want.delay || got.event_time !== want.event_time) begin
            fail_count++;
            if (fail_count <= MaxReports) begin
              $display("mismatch: expected kind %0d ch %0d delay %0d time %0h",
                       want.kind, want.channel, want.delay, want.event_time);
              $display("          actual   kind %0d ch %0d delay %0d time %0h",
                       got.kind, got.channel, got.delay, got.event_time);
            end
          end
        end
      end
      if (s_valid && s_axis_tready) begin
        moved = 1'b1;
        result_q.push_back(decode_record(s_data));
      end
      if (cfg_valid && cfg_ready_o) begin
        moved = 1'b1;
        if (cfg_index == CfgIdxFormat) begin
          fmt_cfg = format_e'(cfg_data[0]);
        end else begin
          ver_cfg = cfg_data;
        end
      end
      if (moved || !busy) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0] cdata;
    logic       fmt;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 21;
    recv_idle_pct = 79;

    // Layout T3 with the reset firmware version: field extremes and every T3 kind.
    record_q.push_back(t3_rec(1'b0, 6'd0, 15'd0, 10'd0));
    record_q.push_back(t3_rec(1'b0, 6'd63, 15'h7FFF, 10'd1023));
    record_q.push_back(t3_rec(1'b1, 6'd1, 15'h7FFF, 10'd5));
    record_q.push_back(t3_rec(1'b1, 6'd15, 15'd0, 10'd1023));
    record_q.push_back(t3_rec(1'b1, 6'd0, 15'd123, 10'd7));
    record_q.push_back(t3_rec(1'b1, 6'd16, 15'd0, 10'd0));
    record_q.push_back(t3_rec(1'b1, 6'd62, 15'h7FFF, 10'd1023));
    record_q.push_back(t3_rec(1'b1, OvfChannel, 15'd0, 10'd0));
    record_q.push_back(t3_rec(1'b1, OvfChannel, 15'h7FFF, 10'd1023));
    record_q.push_back(t3_rec(1'b0, 6'd5, 15'd100, 10'd3));
    wait_idle();

    // Old firmware: a T3 overflow with a count still adds one period.
    write_reg(CfgIdxVersion, HwVersionOld);
    record_q.push_back(t3_rec(1'b1, OvfChannel, 15'd0, 10'd5));
    record_q.push_back(t3_rec(1'b1, 6'd2, 15'd0, 10'd9));
    wait_idle();

    // T2 layout with the old wrap period; the spare data bit is set too.
    write_reg(CfgIdxFormat, 2'b11);
    record_q.push_back(t2_rec(1'b1, OvfChannel, 25'd7));
    record_q.push_back(t2_rec(1'b0, 6'd63, 25'h1FFFFFF));
    record_q.push_back(t2_rec(1'b1, 6'd0, 25'h1FFFFFF));
    record_q.push_back(t2_rec(1'b1, 6'd15, 25'd0));
    record_q.push_back(t2_rec(1'b1, 6'd40, 25'd5));
    record_q.push_back(t2_rec(1'b1, 6'd1, 25'd11));
    wait_idle();

    // Unused version codes behave as the new firmware.
    write_reg(CfgIdxVersion, 2'd3);
    record_q.push_back(t2_rec(1'b1, OvfChannel, 25'd0));
    record_q.push_back(t2_rec(1'b1, OvfChannel, 25'h1FFFFFF));
    record_q.push_back(t2_rec(1'b0, 6'd0, 25'd0));
    record_q.push_back(t2_rec(1'b1, 6'd62, 25'd3));
    wait_idle();
    write_reg(CfgIdxVersion, 2'd0);
    record_q.push_back(t2_rec(1'b1, OvfChannel, 25'd2));
    record_q.push_back(t2_rec(1'b1, 6'd0, 25'd1));

    // Three idling patterns, each walking through four register settings so
    // that all format and version pairs come up.
    for (int ph = 0; ph < 3; ph++) begin
      for (int blk = 0; blk < 4; blk++) begin
        wait_idle();
        send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 79 : 0;
        recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 21 : 0;
        fmt      = ((ph * 4 + blk) % 2) == 1;
        cdata    = 2'($urandom_range(3));
        cdata[0] = fmt;
        write_reg(CfgIdxFormat, cdata);
        write_reg(CfgIdxVersion, 2'(((ph * 4 + blk) / 2) % 4));
        if (ph == 2 && blk == 1) begin
          // Maximal T2 overflows drive the base into its upper bits, with a
          // photon now and then to expose them.
          for (int n = 0; n < WrapRecords; n++) begin
            if (n % 16 == 0) begin
              record_q.push_back(t2_rec(1'b0, 6'($urandom_range(63)), 25'h1FFFFFF));
            end
            record_q.push_back(32'hFFFF_FFFF);
          end
        end
        // Receiver holds off while the sender keeps offering records.
        if (ph == 2 && blk == 2) hold_req = 1'b1;
        repeat (BlockItems) record_q.push_back(random_record());
      end
    end

    wait_idle();
    repeat (EndPause) @(posedge clk_i);
    if (fail_count == 0 && result_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> timetag_record_decoder_core.f
hw/rtl/trdec_pkg.sv
hw/rtl/trdec_cfg.sv
hw/rtl/trdec_decode.sv
hw/rtl/timetag_record_decoder_core.sv
hw/rtl/trdec_checker.sv
bench/tb_timetag_record_decoder_core.sv
